>>> design/ipv4frt_pkg.sv
// Shared types and constants of the IPv4 fragment reassembly tracker.
// Depends on nothing; the front end, queue, sequencer and top level import it.
package ipv4frt_pkg;

    localparam logic OP_FRAGMENT = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    localparam logic [3:0]  MIN_IHL         = 4'd5;
    localparam logic [15:0] TTL_SCALE_RESET = 16'd1000;

    // word counter of the coverage bitmap: a datagram spans at most 128 words
    localparam int unsigned WORD_CNT_W = 8;

    typedef enum logic [2:0] {
        ST_PASS     = 3'd0,
        ST_STORED   = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_FULL     = 3'd3,
        ST_EXPIRED  = 3'd4,
        ST_BADLEN   = 3'd5
    } status_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ident;
        logic [7:0]  protocol;
        logic [12:0] frag_offset;
        logic        more_fragments;
        logic [15:0] total_len;
        logic [3:0]  header_words;
        logic [7:0]  ttl;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  context_index;
        logic [15:0] payload_length;
        logic [5:0]  header_bytes;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        WK_PASS,
        WK_BADLEN,
        WK_FRAG,
        WK_TICK
    } work_kind_t;

    // classified item handed from the front end to the sequencer
    typedef struct packed {
        work_kind_t  kind;
        logic [31:0] src;
        logic [31:0] dst;
        logic [23:0] keyip;
        logic [12:0] fo;
        logic        mf;
        logic [3:0]  hw;
        logic [15:0] endb;
        logic [13:0] endblk;
        logic [23:0] life_add;
    } work_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [23:0] keyip;
        logic        length_known;
        logic [15:0] payload_total;
        logic [3:0]  first_hw;
        logic [47:0] deadline;
    } ctx_t;

endpackage

>>> design/ipv4frt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipv4frt_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ipv4frt_queue.sv
// Two-entry queue of classified work between front end and sequencer.
// Depends on ipv4frt_pkg.
module ipv4frt_queue
    import ipv4frt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t wdata,
    input  logic  pop,
    output work_t rdata,
    output logic  full,
    output logic  empty
);

    work_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> design/ipv4frt_front.sv
// Front end: takes input items, holds the lifetime scale register and
// classifies each item (pass, bad length, fragment, tick). Uses ipv4frt_pkg.
module ipv4frt_front
    import ipv4frt_pkg::*;
#(
    parameter int unsigned BLOCKS_PER_DATAGRAM = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    input  logic        ttl_scale_we,
    input  logic [15:0] ttl_scale_wdata,
    input  logic        init_busy,
    input  logic        q_full,
    output logic        q_push,
    output work_t       q_data
);

    localparam logic [14:0] BLOCK_LIMIT = 15'(BLOCKS_PER_DATAGRAM);

    logic        st_valid_reg;
    logic        st_valid_next;
    item_t       st_reg;
    logic [15:0] scale_reg;
    logic        accept;

    logic [5:0]  ihl;
    logic        short_len;
    logic [15:0] payload;
    logic [16:0] endb;
    logic [13:0] nblk;
    logic [14:0] endblk;
    logic        bad;

    assign item_stall = init_busy || (st_valid_reg && q_full);
    assign accept     = item_valid && !item_stall;
    assign q_push     = st_valid_reg && !q_full;

    always_comb
    begin
        ihl       = {st_reg.header_words, 2'b00};
        short_len = st_reg.total_len < 16'(ihl);
        payload   = st_reg.total_len - 16'(ihl);
        endb      = 17'({st_reg.frag_offset, 3'b000}) + 17'(payload);
        nblk      = 14'((17'(payload) + 17'd7) >> 3);
        endblk    = 15'(st_reg.frag_offset) + 15'(nblk);
        bad       = (st_reg.header_words < MIN_IHL) || short_len || endb[16]
                    || (endblk > BLOCK_LIMIT);

        q_data.src      = st_reg.src_addr;
        q_data.dst      = st_reg.dst_addr;
        q_data.keyip    = {st_reg.ident, st_reg.protocol};
        q_data.fo       = st_reg.frag_offset;
        q_data.mf       = st_reg.more_fragments;
        q_data.hw       = st_reg.header_words;
        q_data.endb     = endb[15:0];
        q_data.endblk   = endblk[13:0];
        q_data.life_add = 24'(st_reg.ttl) * 24'(scale_reg);

        if (st_reg.opcode == OP_TICK)
        begin
            q_data.kind = WK_TICK;
        end
        else if (!st_reg.more_fragments && (st_reg.frag_offset == 13'd0))
        begin
            q_data.kind = WK_PASS;
        end
        else if (bad)
        begin
            q_data.kind = WK_BADLEN;
        end
        else
        begin
            q_data.kind = WK_FRAG;
        end

        st_valid_next = accept ? 1'b1 : (q_push ? 1'b0 : st_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            scale_reg    <= TTL_SCALE_RESET;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            if (ttl_scale_we)
            begin
                scale_reg <= ttl_scale_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg <= item;
        end
    end

endmodule

>>> design/ipv4frt_back.sv
// Sequencer: context lookup and allocation, bitmap update and completion
// check, expiry scan, bitmap clearing and the result register.
// Uses ipv4frt_pkg and two ipv4frt_ram instances.
module ipv4frt_back
    import ipv4frt_pkg::*;
#(
    parameter int unsigned CONTEXTS            = 8,
    parameter int unsigned BLOCKS_PER_DATAGRAM = 8192
) (
    input  logic    clk,
    input  logic    rst_n,
    input  work_t   q_data,
    input  logic    q_empty,
    output logic    q_pop,
    output logic    init_busy,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int unsigned WORDS = (BLOCKS_PER_DATAGRAM + 63) / 64;
    localparam int unsigned DEPTH = CONTEXTS * WORDS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int unsigned CW    = SW + 1;
    localparam int unsigned WCW   = WORD_CNT_W;

    localparam logic [WCW-1:0] WORDS_N   = WCW'(WORDS);
    localparam logic [WCW-1:0] WORDS_TOP = WCW'(WORDS - 1);
    localparam logic [CW-1:0]  CTX_N     = CW'(CONTEXTS);
    localparam logic [AW-1:0]  DEPTH_TOP = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_LOOK_CHK,
        S_SETUP,
        S_SET,
        S_CHECK,
        S_WB,
        S_CLEAR,
        S_TICK,
        S_TICK_CHK,
        S_RESP
    } state_t;

    function automatic logic [63:0] range_mask(logic [6:0] lo, logic [6:0] hi);
        logic [63:0] upper;
        logic [63:0] lower;
        upper = hi[6] ? {64{1'b1}} : ((64'd1 << hi[5:0]) - 64'd1);
        lower = lo[6] ? 64'd0 : ~((64'd1 << lo[5:0]) - 64'd1);
        return upper & lower;
    endfunction

    state_t           state_reg, state_next;
    state_t           after_reg, after_next;
    state_t           clr_ret_reg, clr_ret_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [CONTEXTS-1:0] valid_reg, valid_next;
    work_t            work_reg, work_next;
    ctx_t             ctx_reg, ctx_next;
    logic [47:0]      life_reg, life_next;
    logic [47:0]      clock_reg, clock_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [WCW-1:0]   w_reg, w_next;
    logic             rp_valid_reg, rp_valid_next;
    logic [WCW-1:0]   rp_w_reg, rp_w_next;
    logic [AW-1:0]    init_reg, init_next;
    logic             held_valid_reg, held_valid_next;
    logic [SW-1:0]    held_reg, held_next;
    result_t          pend_reg, pend_next;
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;

    logic             bm_we;
    logic [AW-1:0]    bm_waddr;
    logic [63:0]      bm_wdata;
    logic [AW-1:0]    bm_raddr;
    logic [63:0]      bm_rdata;
    logic             ctx_we;
    logic [SW-1:0]    ctx_raddr;
    ctx_t             ctx_rd;

    logic [SW-1:0]    cidx;
    logic             any_free;
    logic [SW-1:0]    free_idx;
    logic             out_free;
    logic [14:0]      wpos;
    logic [14:0]      rpos;
    logic [14:0]      endblk15;
    logic [14:0]      fo15;
    logic [14:0]      cnt_blk;
    logic             set_more;
    logic             check_more;
    logic [6:0]       set_lo;
    logic [6:0]       set_hi;
    logic [6:0]       chk_hi;
    logic [63:0]      set_mask;
    logic [63:0]      chk_mask;
    logic [AW-1:0]    rp_addr;
    logic             key_hit;

    ipv4frt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    ipv4frt_ram #(.WIDTH($bits(ctx_t)), .DEPTH(CONTEXTS)) u_ctx (
        .clk   (clk),
        .we    (ctx_we),
        .waddr (slot_reg),
        .wdata (ctx_next),
        .raddr (ctx_raddr),
        .rdata (ctx_rd)
    );

    assign cidx         = cnt_reg[SW-1:0];
    assign ctx_raddr    = cidx;
    assign out_free     = !res_valid_reg || !result_stall;
    assign init_busy    = (state_reg == S_INIT);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = CONTEXTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        wpos       = {1'b0, w_reg, 6'b0};
        rpos       = {1'b0, rp_w_reg, 6'b0};
        endblk15   = 15'(work_reg.endblk);
        fo15       = 15'(work_reg.fo);
        cnt_blk    = 15'((17'(ctx_reg.payload_total) + 17'd7) >> 3);
        set_more   = (wpos < endblk15) && (w_reg < WORDS_N);
        check_more = (wpos < cnt_blk) && (w_reg < WORDS_N);
        set_lo     = (fo15 > rpos) ? 7'(fo15 - rpos) : 7'd0;
        set_hi     = (endblk15 >= rpos + 15'd64) ? 7'd64 : 7'(endblk15 - rpos);
        chk_hi     = (cnt_blk >= rpos + 15'd64) ? 7'd64 : 7'(cnt_blk - rpos);
        set_mask   = range_mask(set_lo, set_hi);
        chk_mask   = range_mask(7'd0, chk_hi);
        rp_addr    = AW'(32'(base_reg) + 32'(rp_w_reg));
        key_hit    = (ctx_rd.src == work_reg.src) && (ctx_rd.dst == work_reg.dst)
                     && (ctx_rd.keyip == work_reg.keyip);
    end

    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        clr_ret_next    = clr_ret_reg;
        cnt_next        = cnt_reg;
        slot_next       = slot_reg;
        valid_next      = valid_reg;
        work_next       = work_reg;
        ctx_next        = ctx_reg;
        life_next       = life_reg;
        clock_next      = clock_reg;
        base_next       = base_reg;
        w_next          = w_reg;
        rp_valid_next   = rp_valid_reg;
        rp_w_next       = rp_w_reg;
        init_next       = init_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        pend_next       = pend_reg;
        res_valid_next  = res_valid_reg && result_stall;
        res_next        = res_reg;
        q_pop           = 1'b0;
        bm_we           = 1'b0;
        bm_waddr        = AW'(32'(base_reg) + 32'(w_reg));
        bm_wdata        = 64'd0;
        bm_raddr        = AW'(32'(base_reg) + 32'(w_reg));
        ctx_we          = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // clear the whole bitmap after reset, one word a cycle
                bm_we    = 1'b1;
                bm_waddr = init_reg;
                if (init_reg == DEPTH_TOP)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_next = init_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_data;
                    cnt_next   = '0;
                    after_next = S_IDLE;
                    case (q_data.kind)
                        WK_TICK:
                        begin
                            clock_next = clock_reg + 48'd1;
                            state_next = S_TICK;
                        end
                        WK_PASS:
                        begin
                            pend_next  = '{ST_PASS, 6'd0, 16'd0, 6'd0, 1'b1};
                            state_next = S_RESP;
                        end
                        WK_BADLEN:
                        begin
                            pend_next  = '{ST_BADLEN, 6'd0, 16'd0, 6'd0, 1'b1};
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            life_next  = clock_reg + 48'(q_data.life_add);
                            state_next = S_LOOK;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if (cnt_reg == CTX_N)
                begin
                    if (any_free)
                    begin
                        slot_next  = free_idx;
                        ctx_next   = '{work_reg.src, work_reg.dst, work_reg.keyip,
                                       1'b0, 16'd0, 4'd0, life_reg};
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        pend_next  = '{ST_FULL, 6'd0, 16'd0, 6'd0, 1'b1};
                        after_next = S_IDLE;
                        state_next = S_RESP;
                    end
                end
                else if (valid_reg[cidx])
                begin
                    state_next = S_LOOK_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_LOOK_CHK:
            begin
                if (key_hit)
                begin
                    slot_next  = cidx;
                    ctx_next   = ctx_rd;
                    state_next = S_SETUP;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_LOOK;
                end
            end

            S_SETUP:
            begin
                if (!work_reg.mf)
                begin
                    ctx_next.payload_total = work_reg.endb;
                    ctx_next.length_known  = 1'b1;
                end
                if (work_reg.fo == 13'd0)
                begin
                    ctx_next.first_hw = work_reg.hw;
                end
                base_next     = AW'(32'(slot_reg) * 32'(WORDS));
                rp_valid_next = 1'b0;
                if (endblk15 > fo15)
                begin
                    w_next     = WCW'(work_reg.fo[12:6]);
                    state_next = S_SET;
                end
                else
                begin
                    w_next     = '0;
                    state_next = S_CHECK;
                end
            end

            S_SET:
            begin
                // read word w while merging the word read in the previous cycle
                if (rp_valid_reg)
                begin
                    bm_we    = 1'b1;
                    bm_waddr = rp_addr;
                    bm_wdata = bm_rdata | set_mask;
                end
                if (set_more)
                begin
                    rp_valid_next = 1'b1;
                    rp_w_next     = w_reg;
                    w_next        = w_reg + WCW'(1);
                end
                else
                begin
                    rp_valid_next = 1'b0;
                    if (!rp_valid_reg)
                    begin
                        w_next     = '0;
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (!ctx_reg.length_known)
                begin
                    state_next = S_WB;
                end
                else if (rp_valid_reg && ((bm_rdata & chk_mask) != chk_mask))
                begin
                    rp_valid_next = 1'b0;
                    state_next    = S_WB;
                end
                else if (check_more)
                begin
                    rp_valid_next = 1'b1;
                    rp_w_next     = w_reg;
                    w_next        = w_reg + WCW'(1);
                end
                else if (rp_valid_reg)
                begin
                    rp_valid_next = 1'b0;
                end
                else
                begin
                    // complete: report, drop the context and clear its bitmap
                    pend_next = '{ST_COMPLETE, 6'(slot_reg), ctx_reg.payload_total,
                                  6'({ctx_reg.first_hw, 2'b00}), 1'b1};
                    valid_next[slot_reg] = 1'b0;
                    w_next       = '0;
                    after_next   = S_CLEAR;
                    clr_ret_next = S_IDLE;
                    state_next   = S_RESP;
                end
            end

            S_WB:
            begin
                if (life_reg > ctx_reg.deadline)
                begin
                    ctx_next.deadline = life_reg;
                end
                ctx_we               = 1'b1;
                valid_next[slot_reg] = 1'b1;
                pend_next  = '{ST_STORED, 6'(slot_reg), 16'd0, 6'd0, 1'b1};
                after_next = S_IDLE;
                state_next = S_RESP;
            end

            S_CLEAR:
            begin
                bm_we = 1'b1;
                if (w_reg == WORDS_TOP)
                begin
                    state_next = clr_ret_reg;
                end
                else
                begin
                    w_next = w_reg + WCW'(1);
                end
            end

            S_TICK:
            begin
                if (cnt_reg == CTX_N)
                begin
                    if (held_valid_reg)
                    begin
                        pend_next       = '{ST_EXPIRED, 6'(held_reg), 16'd0, 6'd0, 1'b1};
                        held_valid_next = 1'b0;
                        after_next      = S_IDLE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (valid_reg[cidx])
                begin
                    state_next = S_TICK_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_TICK_CHK:
            begin
                if (ctx_rd.deadline < clock_reg)
                begin
                    // hold one expiry back so the final one can carry last
                    valid_next[cidx] = 1'b0;
                    base_next    = AW'(32'(cidx) * 32'(WORDS));
                    w_next       = '0;
                    cnt_next     = cnt_reg + CW'(1);
                    clr_ret_next = S_TICK;
                    held_next    = cidx;
                    if (held_valid_reg)
                    begin
                        pend_next  = '{ST_EXPIRED, 6'(held_reg), 16'd0, 6'd0, 1'b0};
                        after_next = S_CLEAR;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        held_valid_next = 1'b1;
                        state_next      = S_CLEAR;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_TICK;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = pend_reg;
                    state_next     = after_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            after_reg      <= S_IDLE;
            clr_ret_reg    <= S_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            clock_reg      <= 48'd0;
            w_reg          <= '0;
            rp_valid_reg   <= 1'b0;
            init_reg       <= '0;
            held_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            after_reg      <= after_next;
            clr_ret_reg    <= clr_ret_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            clock_reg      <= clock_next;
            w_reg          <= w_next;
            rp_valid_reg   <= rp_valid_next;
            init_reg       <= init_next;
            held_valid_reg <= held_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        work_reg  <= work_next;
        ctx_reg   <= ctx_next;
        life_reg  <= life_next;
        base_reg  <= base_next;
        rp_w_reg  <= rp_w_next;
        held_reg  <= held_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
    end

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT) |=> (state_reg != S_INIT))
        else $error("bitmap clearing pass entered again");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> ((state_reg == S_IDLE) && !q_empty))
        else $error("queue popped outside idle or while empty");

    a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && out_free) |=> res_valid_reg)
        else $error("pending result not loaded into output register");

    a_complete_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status == ST_COMPLETE))
        |-> (res_reg.header_bytes >= 6'd20))
        else $error("completed datagram without offset-zero header length");

endmodule

>>> design/ipv4_fragment_reassembly_tracker.sv
// IPv4 fragment reassembly tracker, top level: front end, work queue and
// sequencer. Depends on ipv4frt_pkg, ipv4frt_front, ipv4frt_queue, ipv4frt_back.
// Pass and bad-length items go from the front-end register through the queue
// and S_RESP into the result register. Fragment: a key scan over the contexts,
// then the covered words are set and the checked words tested, one bitmap word per
// cycle; a completion also clears the context's bitmap. Tick: a scan of every context,
// clearing the bitmap of each expired one. After reset the whole bitmap memory
// is cleared, with item_stall high.
module ipv4_fragment_reassembly_tracker
    import ipv4frt_pkg::*;
#(
    parameter int unsigned CONTEXTS            = 8,
    parameter int unsigned BLOCKS_PER_DATAGRAM = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        ttl_scale_we,
    input  logic [15:0] ttl_scale_wdata
);

    logic  init_busy;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    work_t q_wdata;
    work_t q_rdata;

    ipv4frt_front #(.BLOCKS_PER_DATAGRAM(BLOCKS_PER_DATAGRAM)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .ttl_scale_we    (ttl_scale_we),
        .ttl_scale_wdata (ttl_scale_wdata),
        .init_busy       (init_busy),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_wdata)
    );

    ipv4frt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    ipv4frt_back #(
        .CONTEXTS            (CONTEXTS),
        .BLOCKS_PER_DATAGRAM (BLOCKS_PER_DATAGRAM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_rdata),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
